>>> rtl/vgrm_pkg.sv
// Shared types and constants for the voxel grid ray march block.
// Holds field widths, operation and state codes, and the controller/datapath structs.
// No dependencies.
package vgrm_pkg;

	// Fixed field widths
	localparam int POS_W     = 16;   // Q8.8 position
	localparam int DIR_W     = 16;   // Q2.14 direction
	localparam int STEP_W    = 16;   // Q0.16 sample spacing
	localparam int STEPS_W   = 10;   // last sample index
	localparam int KIND_W    = 8;    // kind field on the ports
	localparam int HIT_W     = 5;    // hit coordinate field
	localparam int CFG_W     = 16;   // config write data
	localparam int CFG_IDX_W = 2;
	localparam int WORLD_W   = 3;    // world size register

	// Position accumulator in units of 2^-30 voxel
	localparam int FRAC_W    = 30;
	localparam int POS_SHIFT = 22;   // Q8.8 -> 2^-30 units
	localparam int ACC_W     = 44;
	localparam int VOX_W     = ACC_W - FRAC_W;
	localparam int DELTA_W   = DIR_W + STEP_W + 1;

	// Config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd3;

	// Config reset values
	localparam logic [WORLD_W-1:0] WORLD_RST = 3'd4;
	localparam logic [STEP_W-1:0]  STEP_RST  = 16'd6554;

	typedef enum logic [1:0] {
		OP_GET   = 2'd0,
		OP_SET   = 2'd1,
		OP_MARCH = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_RUN,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_GET,
		RES_MARCH
	} res_sel_t;

	// Controller -> datapath (and output register) commands
	typedef struct packed {
		logic     clear;       // write zero at clear pointer
		logic     load;        // capture input item
		logic     load_march;  // item is a march (use max_steps)
		logic     prep;        // form per-sample position step
		logic     run;         // issue samples
		logic     do_set;      // write voxel at address stage
		logic     capture;     // latch result
		logic     flush;       // drop samples in flight
		res_sel_t res_sel;
		logic     out_load;    // move result to output register
	} cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic clear_done;
		logic s3_valid;
		logic s3_hit;
		logic s3_last;
	} sts_t;

	typedef struct packed {
		logic              rd_active;
		logic [KIND_W-1:0] rd_kind;
		logic              hit;
		logic [HIT_W-1:0]  hit_x;
		logic [HIT_W-1:0]  hit_y;
		logic [HIT_W-1:0]  hit_z;
	} result_t;

endpackage

>>> rtl/vgrm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module vgrm_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 32768,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/vgrm_ctrl.sv
// Controller state machine for the voxel grid ray march block.
// Depends on vgrm_pkg; drives the datapath through cmd_t and reads sts_t.
module vgrm_ctrl import vgrm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       op,
	output logic             in_ready,
	input  logic             out_free,
	input  sts_t             sts,
	output cmd_t             cmd
);

	state_t state_q, state_n;
	op_t    op_q;
	logic   done;

	// item finishes on its last sample, or on the first hit of a march
	assign done = sts.s3_valid && (sts.s3_last || ((op_q == OP_MARCH) && sts.s3_hit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			op_q    <= OP_NOP;
		end else begin
			state_q <= state_n;
			if (state_q == ST_IDLE && in_valid) begin
				op_q <= op_t'(op);
			end
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) state_n = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_n = ST_PREP;
			end
			ST_PREP: begin
				state_n = (op_q == OP_NOP) ? ST_RESULT : ST_RUN;
			end
			ST_RUN: begin
				if (done) state_n = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.load       = in_valid;
				cmd.load_march = (op_t'(op) == OP_MARCH);
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (op_q == OP_NOP) begin
					cmd.capture = 1'b1;
					cmd.res_sel = RES_NONE;
				end
			end
			ST_RUN: begin
				cmd.run    = 1'b1;
				cmd.do_set = (op_q == OP_SET);
				if (done) begin
					cmd.capture = 1'b1;
					cmd.flush   = 1'b1;
					case (op_q)
						OP_GET:   cmd.res_sel = RES_GET;
						OP_MARCH: cmd.res_sel = RES_MARCH;
						default:  cmd.res_sel = RES_NONE;
					endcase
				end
			end
			ST_RESULT: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/vgrm_dp.sv
// Datapath: position accumulators, voxel locate pipeline, voxel store and result latch.
// Depends on vgrm_pkg and vgrm_ram.
module vgrm_dp import vgrm_pkg::*; #(
	parameter int CHUNK_EDGE   = 8,
	parameter int MAX_CHUNKS_X = 4,
	parameter int MAX_CHUNKS_Y = 4,
	parameter int MAX_CHUNKS_Z = 4,
	parameter int KIND_BITS    = 8,
	localparam int MAXM = (MAX_CHUNKS_X > MAX_CHUNKS_Y) ?
		((MAX_CHUNKS_X > MAX_CHUNKS_Z) ? MAX_CHUNKS_X : MAX_CHUNKS_Z) :
		((MAX_CHUNKS_Y > MAX_CHUNKS_Z) ? MAX_CHUNKS_Y : MAX_CHUNKS_Z),
	localparam int EFF_W = $clog2(MAXM + 1),
	localparam int PLN_W = $clog2(MAXM * MAXM + 1),
	localparam int LIM_W = $clog2(MAXM * CHUNK_EDGE + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic signed [POS_W-1:0]   pos_x,
	input  logic signed [POS_W-1:0]   pos_y,
	input  logic signed [POS_W-1:0]   pos_z,
	input  logic signed [DIR_W-1:0]   dir_x,
	input  logic signed [DIR_W-1:0]   dir_y,
	input  logic signed [DIR_W-1:0]   dir_z,
	input  logic [STEPS_W-1:0]        max_steps,
	input  logic                      wr_active,
	input  logic [KIND_W-1:0]         wr_kind,
	input  logic [STEP_W-1:0]         march_step,
	input  logic [EFF_W-1:0]          eff_x,
	input  logic [PLN_W-1:0]          plane,
	input  logic [LIM_W-1:0]          lim_x,
	input  logic [LIM_W-1:0]          lim_y,
	input  logic [LIM_W-1:0]          lim_z,
	output result_t                   res
);

	localparam int CHUNK_VOX = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
	localparam int DEPTH     = MAX_CHUNKS_X * MAX_CHUNKS_Y * MAX_CHUNKS_Z * CHUNK_VOX;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int DW        = KIND_BITS + 1;
	localparam int CH_W      = $clog2(MAXM + 1);
	localparam int LOC_W     = $clog2(CHUNK_EDGE);
	localparam int CRD_W     = $clog2(MAXM * CHUNK_EDGE);
	localparam int MAG_W     = VOX_W - 1;

	// per-item registers
	logic signed [ACC_W-1:0]   acc_q   [3];
	logic signed [DIR_W-1:0]   dir_q   [3];
	logic signed [DELTA_W-1:0] delta_q [3];
	logic [STEPS_W-1:0]        last_q;
	logic [STEPS_W:0]          k_q;
	logic                      wr_active_q;
	logic [KIND_W-1:0]         wr_kind_q;
	logic [ADDR_W-1:0]         clr_q;

	// locate pipeline
	logic                      valid_s1, valid_s2, valid_s3;
	logic                      in_s1, in_s2, in_s3;
	logic                      last_s1, last_s2, last_s3;
	logic [CH_W-1:0]           chk_s1 [3];
	logic [LOC_W-1:0]          loc_s1 [3];
	logic [HIT_W-1:0]          h_s1   [3];
	logic [HIT_W-1:0]          h_s2   [3];
	logic [HIT_W-1:0]          h_s3   [3];
	logic [ADDR_W-1:0]         addr_s2;

	logic [LIM_W-1:0]          lim    [3];
	logic signed [POS_W-1:0]   pos_in [3];
	logic signed [DIR_W-1:0]   dir_in [3];
	logic [VOX_W-1:0]          vox    [3];
	logic [MAG_W-1:0]          mag    [3];
	logic                      ax_in  [3];
	logic [CH_W-1:0]           chk    [3];
	logic [LOC_W-1:0]          loc    [3];
	logic                      issue;
	logic [ADDR_W-1:0]         chunk_n;
	logic [ADDR_W-1:0]         addr_n;

	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_waddr;
	logic [DW-1:0]             ram_wdata;
	logic [DW-1:0]             ram_rdata;
	result_t                   res_n;
	result_t                   res_q;

	assign lim[0]    = lim_x;
	assign lim[1]    = lim_y;
	assign lim[2]    = lim_z;
	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;
	assign dir_in[0] = dir_x;
	assign dir_in[1] = dir_y;
	assign dir_in[2] = dir_z;

	// a sample issues per run cycle until the last index has gone out
	assign issue = cmd.run && (k_q <= {1'b0, last_q});

	// item capture, step product and accumulation
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int a = 0; a < 3; a++) begin
				acc_q[a] <= {{(ACC_W - POS_W - POS_SHIFT){pos_in[a][POS_W-1]}},
					pos_in[a], {POS_SHIFT{1'b0}}};
				dir_q[a] <= dir_in[a];
			end
			last_q      <= cmd.load_march ? max_steps : '0;
			wr_active_q <= wr_active;
			wr_kind_q   <= wr_kind;
		end else if (issue) begin
			for (int a = 0; a < 3; a++) begin
				acc_q[a] <= acc_q[a] +
					{{(ACC_W - DELTA_W){delta_q[a][DELTA_W-1]}}, delta_q[a]};
			end
		end
		if (cmd.prep) begin
			for (int a = 0; a < 3; a++) begin
				delta_q[a] <= dir_q[a] * $signed({1'b0, march_step});
			end
		end
	end

	// sample counter and clear pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.load) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// floor to voxel, world bounds, split into chunk and local parts
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			vox[a]   = acc_q[a][ACC_W-1 -: VOX_W];
			mag[a]   = vox[a][MAG_W-1:0];
			ax_in[a] = !vox[a][VOX_W-1] && (mag[a] < MAG_W'(lim[a]));
			chk[a]   = '0;
			for (int i = 1; i < MAXM; i++) begin
				if (mag[a] >= MAG_W'(i * CHUNK_EDGE)) chk[a] = CH_W'(i);
			end
			loc[a] = LOC_W'(mag[a][CRD_W-1:0] - CRD_W'(chk[a] * CHUNK_EDGE));
		end
	end

	// chunk number and store address
	always_comb begin
		chunk_n = ADDR_W'(chk_s1[0]) + ADDR_W'(chk_s1[1]) * ADDR_W'(eff_x) +
			ADDR_W'(chk_s1[2]) * ADDR_W'(plane);
		addr_n  = chunk_n * ADDR_W'(CHUNK_VOX) + ADDR_W'(loc_s1[0]) +
			ADDR_W'(loc_s1[1]) * ADDR_W'(CHUNK_EDGE) +
			ADDR_W'(loc_s1[2]) * ADDR_W'(CHUNK_EDGE * CHUNK_EDGE);
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		in_s1   <= ax_in[0] && ax_in[1] && ax_in[2];
		last_s1 <= (k_q == {1'b0, last_q});
		for (int a = 0; a < 3; a++) begin
			chk_s1[a] <= chk[a];
			loc_s1[a] <= loc[a];
			h_s1[a]   <= vox[a][HIT_W-1:0];
			h_s2[a]   <= h_s1[a];
			h_s3[a]   <= h_s2[a];
		end
		addr_s2 <= addr_n;
		in_s2   <= in_s1;
		last_s2 <= last_s1;
		in_s3   <= in_s2;
		last_s3 <= last_s2;
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (cmd.flush) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// voxel store: clear sweep or set write; read every cycle at address stage
	assign ram_we    = cmd.clear || (valid_s2 && in_s2 && cmd.do_set);
	assign ram_waddr = cmd.clear ? clr_q : addr_s2;
	assign ram_wdata = cmd.clear ? '0 : {wr_active_q, KIND_BITS'(wr_kind_q)};

	vgrm_ram #(
		.WIDTH (DW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_s2),
		.rdata (ram_rdata)
	);

	// result forming
	always_comb begin
		res_n = '0;
		case (cmd.res_sel)
			RES_GET: begin
				if (in_s3) begin
					res_n.rd_active = ram_rdata[KIND_BITS];
					res_n.rd_kind   = KIND_W'(ram_rdata[KIND_BITS-1:0]);
				end
			end
			RES_MARCH: begin
				if (in_s3 && ram_rdata[KIND_BITS]) begin
					res_n.hit   = 1'b1;
					res_n.hit_x = h_s3[0];
					res_n.hit_y = h_s3[1];
					res_n.hit_z = h_s3[2];
				end
			end
			default: begin
				res_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_q <= res_n;
		end
	end

	assign res            = res_q;
	assign sts.clear_done = (clr_q == ADDR_W'(DEPTH - 1));
	assign sts.s3_valid   = valid_s3;
	assign sts.s3_hit     = in_s3 && ram_rdata[KIND_BITS];
	assign sts.s3_last    = last_s3;

endmodule

>>> rtl/voxel_grid_ray_march_top.sv
// Top level of the voxel grid ray march block: config registers, output register,
// controller and datapath. Depends on vgrm_pkg, vgrm_ctrl and vgrm_dp.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------------
//  in      | in_valid / in_ready    | op, pos_x/y/z, dir_x/y/z, max_steps, wr_active, wr_kind
//  out     | out_valid / out_ready  | rd_active, rd_kind, hit, hit_x/y/z
//  cfg     | cfg_we (no wait)       | cfg_index, cfg_data
//
// Get and set each use a single sample; a march samples along the ray until the first hit,
// or through sample index max_steps with no hit (the store is read once a cycle through a
// three-stage locate/read pipeline). Op 3 issues no sample and returns an all-zero result.
// After reset a clearing pass writes every store entry once, one per cycle
// (32768 entries at the default sizes); no item is accepted before it ends.
// The next item is accepted while a result waits in the output register.
module voxel_grid_ray_march_top import vgrm_pkg::*; #(
	parameter int CHUNK_EDGE   = 8,
	parameter int MAX_CHUNKS_X = 4,
	parameter int MAX_CHUNKS_Y = 4,
	parameter int MAX_CHUNKS_Z = 4,
	parameter int KIND_BITS    = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              op,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic signed [DIR_W-1:0] dir_x,
	input  logic signed [DIR_W-1:0] dir_y,
	input  logic signed [DIR_W-1:0] dir_z,
	input  logic [STEPS_W-1:0]      max_steps,
	input  logic                    wr_active,
	input  logic [KIND_W-1:0]       wr_kind,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    rd_active,
	output logic [KIND_W-1:0]       rd_kind,
	output logic                    hit,
	output logic [HIT_W-1:0]        hit_x,
	output logic [HIT_W-1:0]        hit_y,
	output logic [HIT_W-1:0]        hit_z,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int MAXM = (MAX_CHUNKS_X > MAX_CHUNKS_Y) ?
		((MAX_CHUNKS_X > MAX_CHUNKS_Z) ? MAX_CHUNKS_X : MAX_CHUNKS_Z) :
		((MAX_CHUNKS_Y > MAX_CHUNKS_Z) ? MAX_CHUNKS_Y : MAX_CHUNKS_Z);
	localparam int EFF_W = $clog2(MAXM + 1);
	localparam int PLN_W = $clog2(MAXM * MAXM + 1);
	localparam int LIM_W = $clog2(MAXM * CHUNK_EDGE + 1);

	logic [WORLD_W-1:0] wcx_q, wcy_q, wcz_q;
	logic [STEP_W-1:0]  step_q;
	logic [EFF_W-1:0]   eff_x_n, eff_y_n, eff_z_n;
	logic [EFF_W-1:0]   eff_x_q;
	logic [PLN_W-1:0]   plane_q;
	logic [LIM_W-1:0]   lim_x_q, lim_y_q, lim_z_q;

	cmd_t    cmd;
	sts_t    sts;
	result_t res;
	result_t out_q;
	logic    out_valid_q;
	logic    out_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcx_q  <= WORLD_RST;
			wcy_q  <= WORLD_RST;
			wcz_q  <= WORLD_RST;
			step_q <= STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHUNKS_X: wcx_q  <= cfg_data[WORLD_W-1:0];
				CFG_CHUNKS_Y: wcy_q  <= cfg_data[WORLD_W-1:0];
				CFG_CHUNKS_Z: wcz_q  <= cfg_data[WORLD_W-1:0];
				CFG_STEP:     step_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// world sizes in use, saturated to the store's extent
	always_comb begin
		eff_x_n = (int'(wcx_q) > MAX_CHUNKS_X) ? EFF_W'(MAX_CHUNKS_X) : EFF_W'(wcx_q);
		eff_y_n = (int'(wcy_q) > MAX_CHUNKS_Y) ? EFF_W'(MAX_CHUNKS_Y) : EFF_W'(wcy_q);
		eff_z_n = (int'(wcz_q) > MAX_CHUNKS_Z) ? EFF_W'(MAX_CHUNKS_Z) : EFF_W'(wcz_q);
	end

	// derived bounds, re-registered every cycle
	always_ff @(posedge clk) begin
		eff_x_q <= eff_x_n;
		plane_q <= PLN_W'(eff_x_n * eff_y_n);
		lim_x_q <= LIM_W'(eff_x_n * CHUNK_EDGE);
		lim_y_q <= LIM_W'(eff_y_n * CHUNK_EDGE);
		lim_z_q <= LIM_W'(eff_z_n * CHUNK_EDGE);
	end

	assign out_free = !out_valid_q || out_ready;

	vgrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_ready (in_ready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	vgrm_dp #(
		.CHUNK_EDGE   (CHUNK_EDGE),
		.MAX_CHUNKS_X (MAX_CHUNKS_X),
		.MAX_CHUNKS_Y (MAX_CHUNKS_Y),
		.MAX_CHUNKS_Z (MAX_CHUNKS_Z),
		.KIND_BITS    (KIND_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.dir_x      (dir_x),
		.dir_y      (dir_y),
		.dir_z      (dir_z),
		.max_steps  (max_steps),
		.wr_active  (wr_active),
		.wr_kind    (wr_kind),
		.march_step (step_q),
		.eff_x      (eff_x_q),
		.plane      (plane_q),
		.lim_x      (lim_x_q),
		.lim_y      (lim_y_q),
		.lim_z      (lim_z_q),
		.res        (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign rd_active = out_q.rd_active;
	assign rd_kind   = out_q.rd_kind;
	assign hit       = out_q.hit;
	assign hit_x     = out_q.hit_x;
	assign hit_y     = out_q.hit_y;
	assign hit_z     = out_q.hit_z;

endmodule
